@@ sv/iowm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iowm_pkg
// Shared types and constants for the I2C display write master.
// ----------------------------------------------------------------------------
package iowm_pkg;

    // transaction phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_START = 4'd1,
        PH_BIT   = 4'd2,
        PH_ACK   = 4'd3,
        PH_STOP  = 4'd4
    } phase_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_CHECK  = 2'd1;

    // control bytes sent ahead of the payload
    localparam logic [7:0] CTRL_CMD  = 8'h00;
    localparam logic [7:0] CTRL_DATA = 8'h40;

    // register reset values
    localparam logic [7:0] SLAVE_ADDR_RESET = 8'd120;
    localparam logic       ACK_CHECK_RESET  = 1'b1;

    // byte order within a transaction
    localparam logic [1:0] BYTE_CTRL    = 2'd1;
    localparam logic [1:0] BYTE_PAYLOAD = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage : iowm_pkg
`default_nettype wire

@@ sv/i2c_oled_write_master_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_oled_write_master_unit
// Bit-level I2C master writing one command or data byte to a display.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one item per pin step. action=1 is a write request (payload,
//   is_data latched if idle, ignored if busy); action=0 is a tick that moves
//   SCL/SDA by one step (start, address byte, control byte, payload byte,
//   each with an acknowledge clock, then stop). sda_in is sampled on the
//   acknowledge high step when ack checking is enabled.
//   m_* channel: exactly one result item per input item, carrying the driven
//   pin levels, busy, done (stop finished on this tick) and the nack flag.
//   cfg_* channel: register writes (0 slave address, 1 ack check), always
//   ready; write only while idle.
// Timing:
//   A result is registered, valid in the cycle after its item is accepted.
//   One item is taken every cycle unless a result is stuck: the whole pin-step
//   update is a single pass of logic between the state and result registers.
// Reset:
//   aresetn low returns to idle with both lines released, nack cleared and
//   the registers at their defaults (address 120, ack check on).
// Stall:
//   The result register holds while m_ready is low; s_ready follows
//   !m_valid || m_ready, so input stops only while a result is stuck.
// ----------------------------------------------------------------------------
module i2c_oled_write_master_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input items
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_action,
    input  wire logic [7:0]                         s_payload,
    input  wire logic                               s_is_data,
    input  wire logic                               s_sda_in,
    // result items
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_scl,
    output logic                                    m_sda,
    output logic                                    m_busy_res,
    output logic                                    m_done_res,
    output logic                                    m_nack,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [iowm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                         cfg_data
);

    // configuration
    logic [7:0] slave_addr_reg;
    logic       ack_check_reg;

    // transaction state
    iowm_pkg::phase_t phase_reg, phase_next;
    logic [1:0] step_reg, step_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [1:0] byte_idx_reg, byte_idx_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] held_payload_reg, held_payload_next;
    logic       held_is_data_reg, held_is_data_next;
    logic       nack_reg, nack_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       done_next;

    // result register
    logic m_valid_reg;
    logic out_scl_reg, out_sda_reg, out_busy_reg, out_done_reg, out_nack_reg;
    logic out_busy_next;

    logic s_accept;
    logic cfg_accept;

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // ------------------------------------------------------------------
    // Next state for one item
    // ------------------------------------------------------------------
    always_comb begin
        logic [3:0] bit_inc;
        logic [1:0] byte_inc;
        bit_inc           = bit_cnt_reg + 4'd1;
        byte_inc          = byte_idx_reg + 2'd1;
        phase_next        = phase_reg;
        step_next         = step_reg;
        bit_cnt_next      = bit_cnt_reg;
        byte_idx_next     = byte_idx_reg;
        shift_next        = shift_reg;
        held_payload_next = held_payload_reg;
        held_is_data_next = held_is_data_reg;
        nack_next         = nack_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        done_next         = 1'b0;

        if (s_action) begin
            // request: latched only when idle, pins untouched
            if (phase_reg == iowm_pkg::PH_IDLE) begin
                held_payload_next = s_payload;
                held_is_data_next = s_is_data;
                nack_next         = 1'b0;
                phase_next        = iowm_pkg::PH_START;
                step_next         = 2'd0;
                bit_cnt_next      = 4'd0;
                byte_idx_next     = 2'd0;
            end
        end else if (phase_reg != iowm_pkg::PH_IDLE) begin
            unique case (phase_reg)
                iowm_pkg::PH_START: begin
                    if (step_reg == 2'd0) begin
                        scl_next  = 1'b1;
                        sda_next  = 1'b0;
                        step_next = 2'd1;
                    end else begin
                        scl_next      = 1'b0;
                        sda_next      = 1'b0;
                        phase_next    = iowm_pkg::PH_BIT;
                        step_next     = 2'd0;
                        bit_cnt_next  = 4'd0;
                        byte_idx_next = 2'd0;
                        shift_next    = slave_addr_reg;
                    end
                end
                iowm_pkg::PH_BIT: begin
                    case (step_reg)
                        2'd0: begin
                            scl_next  = 1'b0;
                            sda_next  = shift_reg[7];
                            step_next = 2'd1;
                        end
                        2'd1: begin
                            scl_next  = 1'b1;
                            step_next = 2'd2;
                        end
                        default: begin
                            scl_next     = 1'b0;
                            shift_next   = {shift_reg[6:0], 1'b0};
                            bit_cnt_next = bit_inc;
                            step_next    = 2'd0;
                            if (bit_inc >= iowm_pkg::BITS_PER_BYTE) begin
                                bit_cnt_next = 4'd0;
                                phase_next   = iowm_pkg::PH_ACK;
                            end
                        end
                    endcase
                end
                iowm_pkg::PH_ACK: begin
                    sda_next = 1'b1;
                    case (step_reg)
                        2'd0: begin
                            scl_next  = 1'b0;
                            step_next = 2'd1;
                        end
                        2'd1: begin
                            scl_next  = 1'b1;
                            step_next = 2'd2;
                            if (ack_check_reg && s_sda_in) begin
                                nack_next = 1'b1;
                            end
                        end
                        default: begin
                            scl_next      = 1'b0;
                            step_next     = 2'd0;
                            byte_idx_next = byte_inc;
                            if (byte_inc == iowm_pkg::BYTE_CTRL) begin
                                shift_next = held_is_data_reg ? iowm_pkg::CTRL_DATA
                                                              : iowm_pkg::CTRL_CMD;
                                phase_next = iowm_pkg::PH_BIT;
                            end else if (byte_inc == iowm_pkg::BYTE_PAYLOAD) begin
                                shift_next = held_payload_reg;
                                phase_next = iowm_pkg::PH_BIT;
                            end else begin
                                phase_next = iowm_pkg::PH_STOP;
                            end
                        end
                    endcase
                end
                iowm_pkg::PH_STOP: begin
                    case (step_reg)
                        2'd0: begin
                            scl_next  = 1'b0;
                            sda_next  = 1'b0;
                            step_next = 2'd1;
                        end
                        2'd1: begin
                            scl_next  = 1'b1;
                            sda_next  = 1'b0;
                            step_next = 2'd2;
                        end
                        default: begin
                            scl_next      = 1'b1;
                            sda_next      = 1'b1;
                            phase_next    = iowm_pkg::PH_IDLE;
                            step_next     = 2'd0;
                            bit_cnt_next  = 4'd0;
                            byte_idx_next = 2'd0;
                            done_next     = 1'b1;
                        end
                    endcase
                end
                default: begin
                    // unknown phase code: recover to idle, lines released
                    phase_next    = iowm_pkg::PH_IDLE;
                    step_next     = 2'd0;
                    bit_cnt_next  = 4'd0;
                    byte_idx_next = 2'd0;
                    scl_next      = 1'b1;
                    sda_next      = 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result fields for one item
    // ------------------------------------------------------------------
    always_comb begin
        out_busy_next = (phase_next != iowm_pkg::PH_IDLE);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= iowm_pkg::SLAVE_ADDR_RESET;
            ack_check_reg  <= iowm_pkg::ACK_CHECK_RESET;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                iowm_pkg::CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data;
                iowm_pkg::CFG_ACK_CHECK:  ack_check_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= iowm_pkg::PH_IDLE;
            step_reg     <= 2'd0;
            bit_cnt_reg  <= 4'd0;
            byte_idx_reg <= 2'd0;
            nack_reg     <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
        end else if (s_accept) begin
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_idx_reg <= byte_idx_next;
            nack_reg     <= nack_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
        end
    end

    // payload holding registers, loaded before first use
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            shift_reg        <= shift_next;
            held_payload_reg <= held_payload_next;
            held_is_data_reg <= held_is_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_scl_reg  <= scl_next;
            out_sda_reg  <= sda_next;
            out_busy_reg <= out_busy_next;
            out_done_reg <= done_next;
            out_nack_reg <= nack_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_scl      = out_scl_reg;
    assign m_sda      = out_sda_reg;
    assign m_busy_res = out_busy_reg;
    assign m_done_res = out_done_reg;
    assign m_nack     = out_nack_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a finished stop leaves both lines released and the master idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> (m_scl && m_sda && !m_busy_res))
        else $error("done without released lines or while busy");

    // an accepted item always yields a result on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted item produced no result");

    // idle means the step counters are cleared
    a_idle_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == iowm_pkg::PH_IDLE) |->
            (step_reg == 2'd0 && bit_cnt_reg == 4'd0 && byte_idx_reg == 2'd0))
        else $error("idle with nonzero step counters");

    // the bus is released whenever the master reports itself idle
    a_idle_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> (m_scl && m_sda))
        else $error("lines driven while idle");

endmodule : i2c_oled_write_master_unit
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the I2C display write master one pin step at a time. A short table
// of items runs right after reset, then random traffic under several address
// and ack-check settings. Each result item is compared with the table's
// expected pins where given, else with a local model of the pin sequencer.
// ----------------------------------------------------------------------------
module testbench;

    // expected pins and flags for one result item
    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic nack;
    } pin_result_t;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic        act;
        logic [7:0]  byte_val;
        logic        data_flag;
        logic        sda_smp;
        logic        typed;
        pin_result_t want;
    } dir_row_t;

    localparam int DIR_ROWS_N = 20;
    localparam int PHASES_N   = 5;
    localparam int PHASE_ITEMS = 140;
    // index past the register map; a write there must change nothing
    localparam logic [iowm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
        // tick while idle right after reset: lines released
        '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
        // request, all-ones data byte: latched, pins hold
        '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        // request while busy: dropped
        '{1'b1, 8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        // start: SDA falls with SCL high, then SCL falls
        '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        // address bits, junk on the unused fields
        '{1'b0, 8'hA5, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 8'h5A, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 8'h80, 1'b1, 1'b0, 1'b0, '0},
        // another request mid-byte, still dropped
        '{1'b1, 8'h01, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 8'h01, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 8'h7F, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 8'hFE, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 8'h33, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 8'hCC, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 8'h0F, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 8'hF0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 8'h55, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 8'hAA, 1'b0, 1'b0, 1'b0, '0}
    };

    // address / ack-check per random phase; the last phase picks its own
    localparam logic [7:0] PHASE_ADDR [0:PHASES_N-1] = '{8'd120, 8'h00, 8'hFF, 8'hFF, 8'h00};
    localparam logic       PHASE_ACK  [0:PHASES_N-1] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_action;
    logic [7:0]                       s_payload;
    logic                             s_is_data;
    logic                             s_sda_in;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_scl;
    logic                             m_sda;
    logic                             m_busy_res;
    logic                             m_done_res;
    logic                             m_nack;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [iowm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                       cfg_data;

    i2c_oled_write_master_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_payload  (s_payload),
        .s_is_data  (s_is_data),
        .s_sda_in   (s_sda_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_scl      (m_scl),
        .m_sda      (m_sda),
        .m_busy_res (m_busy_res),
        .m_done_res (m_done_res),
        .m_nack     (m_nack),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // local copy of the sequencer state and its registers
    iowm_pkg::phase_t seq_phase;
    logic [1:0]  seq_step;
    logic [3:0]  seq_bits;
    logic [1:0]  seq_byte_no;
    logic [7:0]  seq_shift;
    logic [7:0]  held_byte;
    logic        held_data;
    logic        nack_seen;
    logic        scl_lvl;
    logic        sda_lvl;
    logic [7:0]  addr_reg;
    logic        ackchk_reg;

    pin_result_t pending_pins [$];   // expected result items, oldest first
    logic        calm;               // no idling on either side while set
    int          errors;
    int          items_sent;
    int          writes_done;
    int          nacked_writes;
    int          settings_run;

    // ------------------------------------------------------------------------
    // Pin sequencer model: applies one item, returns the result item it makes.
    // ------------------------------------------------------------------------
    function automatic pin_result_t bus_step(input logic act, input logic [7:0] byte_val,
                                             input logic data_flag, input logic sda_smp);
        pin_result_t r;
        r.done = 1'b0;
        if (act) begin
            // requests only land while idle
            if (seq_phase == iowm_pkg::PH_IDLE) begin
                held_byte   = byte_val;
                held_data   = data_flag;
                nack_seen   = 1'b0;
                seq_phase   = iowm_pkg::PH_START;
                seq_step    = 2'd0;
                seq_bits    = 4'd0;
                seq_byte_no = 2'd0;
            end
        end else if (seq_phase != iowm_pkg::PH_IDLE) begin
            case (seq_phase)
                iowm_pkg::PH_START: begin
                    if (seq_step == 2'd0) begin
                        scl_lvl  = 1'b1;
                        sda_lvl  = 1'b0;
                        seq_step = 2'd1;
                    end else begin
                        scl_lvl     = 1'b0;
                        sda_lvl     = 1'b0;
                        seq_phase   = iowm_pkg::PH_BIT;
                        seq_step    = 2'd0;
                        seq_bits    = 4'd0;
                        seq_byte_no = 2'd0;
                        seq_shift   = addr_reg;
                    end
                end
                iowm_pkg::PH_BIT: begin
                    if (seq_step == 2'd0) begin
                        scl_lvl  = 1'b0;
                        sda_lvl  = seq_shift[7];
                        seq_step = 2'd1;
                    end else if (seq_step == 2'd1) begin
                        scl_lvl  = 1'b1;
                        seq_step = 2'd2;
                    end else begin
                        scl_lvl   = 1'b0;
                        seq_shift = {seq_shift[6:0], 1'b0};
                        seq_bits  = seq_bits + 4'd1;
                        seq_step  = 2'd0;
                        if (seq_bits >= iowm_pkg::BITS_PER_BYTE) begin
                            seq_bits  = 4'd0;
                            seq_phase = iowm_pkg::PH_ACK;
                        end
                    end
                end
                iowm_pkg::PH_ACK: begin
                    sda_lvl = 1'b1;
                    if (seq_step == 2'd0) begin
                        scl_lvl  = 1'b0;
                        seq_step = 2'd1;
                    end else if (seq_step == 2'd1) begin
                        // slave should hold SDA low here
                        scl_lvl = 1'b1;
                        if (ackchk_reg && sda_smp)
                            nack_seen = 1'b1;
                        seq_step = 2'd2;
                    end else begin
                        scl_lvl     = 1'b0;
                        seq_step    = 2'd0;
                        seq_byte_no = seq_byte_no + 2'd1;
                        if (seq_byte_no == iowm_pkg::BYTE_CTRL) begin
                            seq_shift = held_data ? iowm_pkg::CTRL_DATA : iowm_pkg::CTRL_CMD;
                            seq_phase = iowm_pkg::PH_BIT;
                        end else if (seq_byte_no == iowm_pkg::BYTE_PAYLOAD) begin
                            seq_shift = held_byte;
                            seq_phase = iowm_pkg::PH_BIT;
                        end else begin
                            seq_phase = iowm_pkg::PH_STOP;
                        end
                    end
                end
                iowm_pkg::PH_STOP: begin
                    // SDA goes low before SCL rises, then SDA releases
                    if (seq_step == 2'd0) begin
                        scl_lvl  = 1'b0;
                        sda_lvl  = 1'b0;
                        seq_step = 2'd1;
                    end else if (seq_step == 2'd1) begin
                        scl_lvl  = 1'b1;
                        sda_lvl  = 1'b0;
                        seq_step = 2'd2;
                    end else begin
                        scl_lvl     = 1'b1;
                        sda_lvl     = 1'b1;
                        seq_phase   = iowm_pkg::PH_IDLE;
                        seq_step    = 2'd0;
                        seq_bits    = 4'd0;
                        seq_byte_no = 2'd0;
                        r.done      = 1'b1;
                    end
                end
                default: begin
                    seq_phase   = iowm_pkg::PH_IDLE;
                    seq_step    = 2'd0;
                    seq_bits    = 4'd0;
                    seq_byte_no = 2'd0;
                    scl_lvl     = 1'b1;
                    sda_lvl     = 1'b1;
                end
            endcase
        end
        r.scl  = scl_lvl;
        r.sda  = sda_lvl;
        r.busy = (seq_phase != iowm_pkg::PH_IDLE);
        r.nack = nack_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel: optional idle cycles, then hold the item until taken.
    // Handshake is sampled on the falling edge, where everything is settled.
    // ------------------------------------------------------------------------
    task automatic send_step(input logic act, input logic [7:0] byte_val,
                             input logic data_flag, input logic sda_smp,
                             input logic typed, input pin_result_t want);
        pin_result_t got;
        while (!calm && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_payload <= byte_val;
        s_is_data <= data_flag;
        s_sda_in  <= sda_smp;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        // item taken at this edge
        got = bus_step(act, byte_val, data_flag, sda_smp);
        pending_pins.push_back(typed ? want : got);
        items_sent++;
    endtask

    // ticks until the current write has finished its stop
    task automatic finish_write();
        while (seq_phase != iowm_pkg::PH_IDLE)
            send_step(1'b0, 8'($urandom), 1'($urandom), 1'b0, 1'b0, '0);
    endtask

    // wait for every expected result item, then a short settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [iowm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        if (idx == iowm_pkg::CFG_SLAVE_ADDR)
            addr_reg = val;
        else if (idx == iowm_pkg::CFG_ACK_CHECK)
            ackchk_reg = val[0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // result side backpressure: about a quarter of cycles stalled
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compares each taken result item with the oldest one
    // expected.
    // ------------------------------------------------------------------------
    initial begin : result_check
        pin_result_t want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_pins.size() == 0) begin
                    $error("result item with none expected: scl=%0b sda=%0b busy=%0b",
                           m_scl, m_sda, m_busy_res);
                    errors++;
                end else begin
                    want = pending_pins.pop_front();
                    if (m_scl !== want.scl) begin
                        $error("scl: expected %0b, got %0b", want.scl, m_scl);
                        errors++;
                    end
                    if (m_sda !== want.sda) begin
                        $error("sda: expected %0b, got %0b", want.sda, m_sda);
                        errors++;
                    end
                    if (m_busy_res !== want.busy) begin
                        $error("busy_res: expected %0b, got %0b", want.busy, m_busy_res);
                        errors++;
                    end
                    if (m_done_res !== want.done) begin
                        $error("done_res: expected %0b, got %0b", want.done, m_done_res);
                        errors++;
                    end
                    if (m_nack !== want.nack) begin
                        $error("nack: expected %0b, got %0b", want.nack, m_nack);
                        errors++;
                    end
                    if (want.done) begin
                        writes_done++;
                        if (want.nack)
                            nacked_writes++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int          counted;
        logic        act;
        logic        smp;
        logic [7:0]  addr_val;
        logic        ack_val;

        errors        = 0;
        items_sent    = 0;
        writes_done   = 0;
        nacked_writes = 0;
        settings_run  = 0;
        calm          = 1'b0;

        // model state after reset
        seq_phase   = iowm_pkg::PH_IDLE;
        seq_step    = 2'd0;
        seq_bits    = 4'd0;
        seq_byte_no = 2'd0;
        seq_shift   = 8'h00;
        held_byte   = 8'h00;
        held_data   = 1'b0;
        nack_seen   = 1'b0;
        scl_lvl     = 1'b1;
        sda_lvl     = 1'b1;
        addr_reg    = iowm_pkg::SLAVE_ADDR_RESET;
        ackchk_reg  = iowm_pkg::ACK_CHECK_RESET;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_action  <= 1'b0;
        s_payload <= 8'h00;
        s_is_data <= 1'b0;
        s_sda_in  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= iowm_pkg::CFG_SLAVE_ADDR;
        cfg_data  <= 8'h00;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset register values
        for (int i = 0; i < DIR_ROWS_N; i++)
            send_step(DIR_ROWS[i].act, DIR_ROWS[i].byte_val, DIR_ROWS[i].data_flag,
                      DIR_ROWS[i].sda_smp, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        finish_write();
        wait_drained();

        // random phases, one register setting each; the second runs with
        // no idling at all
        for (int p = 0; p < PHASES_N; p++) begin
            addr_val = (p == PHASES_N - 1) ? 8'($urandom) : PHASE_ADDR[p];
            ack_val  = (p == PHASES_N - 1) ? 1'($urandom) : PHASE_ACK[p];
            write_reg(iowm_pkg::CFG_SLAVE_ADDR, addr_val);
            write_reg(iowm_pkg::CFG_ACK_CHECK, ack_val);
            if (p == PHASES_N - 1)
                write_reg(CFG_UNUSED, 8'($urandom));
            settings_run++;
            calm    = (p == 1);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                // mostly well-formed: request when idle, ticks when busy
                if (seq_phase == iowm_pkg::PH_IDLE)
                    act = ($urandom_range(0, 99) < 85);
                else
                    act = ($urandom_range(0, 99) < 5);
                // ack mostly given; elsewhere sda_in is noise
                if (seq_phase == iowm_pkg::PH_ACK && seq_step == 2'd1)
                    smp = ($urandom_range(0, 99) < 15);
                else
                    smp = 1'($urandom);
                if ((act && seq_phase == iowm_pkg::PH_IDLE) ||
                    (!act && seq_phase != iowm_pkg::PH_IDLE))
                    counted++;
                send_step(act, 8'($urandom), 1'($urandom), smp, 1'b0, '0);
            end
            finish_write();
            wait_drained();
            calm = 1'b0;
        end

        repeat (8) @(posedge aclk);
        $display("tb: run covered %0d items, %0d finished writes (%0d with a missing ack)",
                 items_sent, writes_done, nacked_writes);
        $display("tb: register settings exercised after reset: %0d", settings_run);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/iowm_pkg.sv
sv/i2c_oled_write_master_unit.sv
verif/testbench.sv
